@@ rtl/core/wvts_pkg.sv @@
package wvts_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int SAMPLE_W     = 32;
	localparam int LANES        = 3;
	localparam int WORD_W       = SAMPLE_W * LANES;
	localparam int RING_W       = SAMPLE_W + SLOT_W;
	localparam int TOTAL_W      = 38;
	localparam int CONF_W       = 16;
	localparam int CFG_W        = 38;
	localparam int CFG_IDX_W    = 2;
	localparam int TOT_CALC_W   = (RING_W + 2 > TOTAL_W) ? RING_W + 2 : TOTAL_W;

	localparam logic [CFG_IDX_W-1:0] REG_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BASE  = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_TIGHT = CFG_IDX_W'(2);

	typedef logic [SLOT_W-1:0]   slot_t;
	typedef logic [WORD_W-1:0]   word_t;
	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [RING_W-1:0]   ring_sum_t;

	typedef struct packed {
		logic  rd_a_en;
		slot_t rd_a_addr;
		logic  rd_b_en;
		slot_t rd_b_addr;
		logic  wr_en;
		slot_t wr_addr;
	} mem_req_t;

	function automatic sample_t abs_diff(sample_t a, sample_t b);
		logic [SAMPLE_W:0] d;
		d = {a[SAMPLE_W-1], a} - {b[SAMPLE_W-1], b};
		if (d[SAMPLE_W]) begin
			d = -d;
		end
		return d[SAMPLE_W-1:0];
	endfunction

	function automatic slot_t slot_prev(slot_t s);
		return (s == slot_t'(0)) ? slot_t'(WINDOW_DEPTH - 1) : s - slot_t'(1);
	endfunction

	function automatic slot_t slot_next(slot_t s);
		return (s == slot_t'(WINDOW_DEPTH - 1)) ? slot_t'(0) : s + slot_t'(1);
	endfunction

endpackage

@@ rtl/core/wvts_ring_mem.sv @@
module wvts_ring_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  wvts_pkg::mem_req_t req,
	input  wvts_pkg::word_t   wr_data,
	output wvts_pkg::word_t   rd_a_data,
	output wvts_pkg::word_t   rd_b_data
);

	wvts_pkg::word_t                    mem [wvts_pkg::WINDOW_DEPTH];
	logic [wvts_pkg::WINDOW_DEPTH-1:0]  vld_q;
	wvts_pkg::word_t                    rd_a_q;
	wvts_pkg::word_t                    rd_b_q;
	logic                               rd_a_vld_q;
	logic                               rd_b_vld_q;

	// entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_a_en) begin
				rd_a_vld_q <= vld_q[req.rd_a_addr];
			end
			if (req.rd_b_en) begin
				rd_b_vld_q <= vld_q[req.rd_b_addr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= wr_data;
		end
		if (req.rd_a_en) begin
			rd_a_q <= mem[req.rd_a_addr];
		end
		if (req.rd_b_en) begin
			rd_b_q <= mem[req.rd_b_addr];
		end
	end

	assign rd_a_data = rd_a_vld_q ? rd_a_q : '0;
	assign rd_b_data = rd_b_vld_q ? rd_b_q : '0;

endmodule

@@ rtl/core/window_variation_threshold_select_core.sv @@
// Keeps three 16-entry circular windows (spread, midprice, micro-volatility) in one
// packed memory and returns, for every input item, the circular sum of absolute
// neighbour differences over all three windows, a flag set when that total exceeds
// instability_limit, and the tightened or base confidence threshold to match. The
// total is kept incrementally per window: at acceptance the two read ports fetch
// the old entry and its previous neighbour, the next neighbour is read on port A in
// the cycle after (ST_FETCH), then ST_DIFF forms the differences, ST_ACC
// accumulates and writes back, and ST_DONE adds the window sums, compares and loads
// the result. The input is ready again in the cycle after the load, so an item is
// not taken before the last one has been loaded. A result waiting on the output
// does not hold up the next item; only the ST_DONE step waits for the output
// register. Windows read as zero after reset through per-entry valid bits,
// so there is no clearing pass.
module window_variation_threshold_select_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// spread_sample [31:0], mid_sample [63:32], vol_sample [95:64]
	input  logic [95:0]                       s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// instability_total [37:0], confidence_out [53:38], zero [55:54]
	output logic [55:0]                       m_axis_tdata,
	// is_unstable [0]
	output logic [0:0]                        m_axis_tuser,
	input  logic                              cfg_we,
	input  logic [wvts_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wvts_pkg::CFG_W-1:0]        cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_DIFF,
		ST_ACC,
		ST_DONE
	} state_t;

	state_t                             state_q;
	wvts_pkg::slot_t                    slot_q;
	wvts_pkg::word_t                    sample_q;
	wvts_pkg::word_t                    prev_q;
	wvts_pkg::word_t                    old_q;
	logic [wvts_pkg::SAMPLE_W:0]        rem_q [wvts_pkg::LANES];
	logic [wvts_pkg::SAMPLE_W:0]        add_q [wvts_pkg::LANES];
	wvts_pkg::ring_sum_t                ring_q [wvts_pkg::LANES];
	logic [wvts_pkg::TOTAL_W-1:0]       limit_q;
	logic [wvts_pkg::CONF_W-1:0]        base_q;
	logic [wvts_pkg::CONF_W-1:0]        tight_q;
	logic                               m_valid_q;
	logic [wvts_pkg::TOTAL_W-1:0]       m_total_q;
	logic                               m_unstable_q;
	logic [wvts_pkg::CONF_W-1:0]        m_conf_q;

	wvts_pkg::mem_req_t                 mem_req;
	wvts_pkg::word_t                    rd_a_data;
	wvts_pkg::word_t                    rd_b_data;
	logic                               in_accept;
	logic                               load_out;
	logic [wvts_pkg::SAMPLE_W:0]        rem_c [wvts_pkg::LANES];
	logic [wvts_pkg::SAMPLE_W:0]        add_c [wvts_pkg::LANES];
	logic [wvts_pkg::TOT_CALC_W-1:0]    total_full;
	logic [wvts_pkg::TOTAL_W-1:0]       total_sat;
	logic                               unstable_c;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid & s_axis_tready;
	assign load_out      = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

	always_comb begin
		mem_req.rd_a_en   = in_accept || (state_q == ST_FETCH);
		mem_req.rd_a_addr = (state_q == ST_FETCH) ? wvts_pkg::slot_next(slot_q)
		                                          : wvts_pkg::slot_prev(slot_q);
		mem_req.rd_b_en   = in_accept;
		mem_req.rd_b_addr = slot_q;
		mem_req.wr_en     = (state_q == ST_ACC);
		mem_req.wr_addr   = slot_q;
	end

	wvts_ring_mem u_ring_mem (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (mem_req),
		.wr_data   (sample_q),
		.rd_a_data (rd_a_data),
		.rd_b_data (rd_b_data)
	);

	// removed and added neighbour terms per window; rd_a_data holds the next entry here
	always_comb begin
		for (int k = 0; k < wvts_pkg::LANES; k++) begin
			rem_c[k] = {1'b0, wvts_pkg::abs_diff(old_q[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W],
			                                    prev_q[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W])}
			         + {1'b0, wvts_pkg::abs_diff(rd_a_data[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W],
			                                    old_q[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W])};
			add_c[k] = {1'b0, wvts_pkg::abs_diff(sample_q[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W],
			                                    prev_q[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W])}
			         + {1'b0, wvts_pkg::abs_diff(rd_a_data[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W],
			                                    sample_q[k*wvts_pkg::SAMPLE_W +: wvts_pkg::SAMPLE_W])};
		end
	end

	always_comb begin
		total_full = wvts_pkg::TOT_CALC_W'(ring_q[0]) + wvts_pkg::TOT_CALC_W'(ring_q[1])
		           + wvts_pkg::TOT_CALC_W'(ring_q[2]);
		if (total_full > wvts_pkg::TOT_CALC_W'({wvts_pkg::TOTAL_W{1'b1}})) begin
			total_sat = {wvts_pkg::TOTAL_W{1'b1}};
		end else begin
			total_sat = total_full[wvts_pkg::TOTAL_W-1:0];
		end
		unstable_c = (total_sat > limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			base_q  <= '0;
			tight_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				wvts_pkg::REG_LIMIT: limit_q <= cfg_data[wvts_pkg::TOTAL_W-1:0];
				wvts_pkg::REG_BASE:  base_q  <= cfg_data[wvts_pkg::CONF_W-1:0];
				wvts_pkg::REG_TIGHT: tight_q <= cfg_data[wvts_pkg::CONF_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sample_q <= s_axis_tdata;
		end
		if (state_q == ST_FETCH) begin
			prev_q <= rd_a_data;
			old_q  <= rd_b_data;
		end
		if (state_q == ST_DIFF) begin
			rem_q <= rem_c;
			add_q <= add_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < wvts_pkg::LANES; k++) begin
				ring_q[k] <= '0;
			end
		end else if (state_q == ST_ACC) begin
			for (int k = 0; k < wvts_pkg::LANES; k++) begin
				ring_q[k] <= wvts_pkg::RING_W'(({2'b00, ring_q[k]}
				             + (wvts_pkg::RING_W+2)'(add_q[k]))
				             - (wvts_pkg::RING_W+2)'(rem_q[k]));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			slot_q       <= '0;
			m_valid_q    <= 1'b0;
			m_total_q    <= '0;
			m_unstable_q <= 1'b0;
			m_conf_q     <= '0;
		end else begin
			if (m_valid_q && m_axis_tready && !load_out) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						state_q <= ST_FETCH;
					end
				end
				ST_FETCH: state_q <= ST_DIFF;
				ST_DIFF:  state_q <= ST_ACC;
				ST_ACC:   state_q <= ST_DONE;
				ST_DONE: begin
					if (load_out) begin
						m_valid_q    <= 1'b1;
						m_total_q    <= total_sat;
						m_unstable_q <= unstable_c;
						m_conf_q     <= unstable_c ? tight_q : base_q;
						slot_q       <= wvts_pkg::slot_next(slot_q);
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {2'b00, m_conf_q, m_total_q};
	assign m_axis_tuser  = m_unstable_q;

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> m_valid_q)
		else $error("result not presented after load");

	a_slot_advances: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (slot_q == wvts_pkg::slot_next($past(slot_q))))
		else $error("write slot did not advance");

	a_flag_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_unstable_q == (m_total_q > limit_q)))
		else $error("instability flag inconsistent with total");

	a_conf_matches: assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q |-> (m_conf_q == (m_unstable_q ? tight_q : base_q)))
		else $error("confidence output does not follow flag");

endmodule

@@ test/tb_window_variation_threshold_select_core.sv @@
`timescale 1ns / 100ps

module tb_window_variation_threshold_select_core;
	import wvts_pkg::*;

	localparam int          CYCLE_LIMIT = 400000;
	localparam int          PHASE_ITEMS = 165;
	localparam int          HOLD_CYCLES = 64;
	localparam int          CFG_ROW     = 3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);
	localparam longint unsigned TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;

	typedef logic signed [SAMPLE_W-1:0] window_t [WINDOW_DEPTH];

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic               unstable;
		logic [CONF_W-1:0]  conf;
	} reading_t;

	typedef struct {
		logic [SAMPLE_W-1:0] spread;
		logic [SAMPLE_W-1:0] mid;
		logic [SAMPLE_W-1:0] vol;
		bit                  typed;
		reading_t            want;
	} stim_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [95:0]          s_axis_tdata = '0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [55:0]          m_axis_tdata;
	logic [0:0]           m_axis_tuser;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	window_t              spread_win = '{default: '0};
	window_t              mid_win = '{default: '0};
	window_t              vol_win = '{default: '0};
	int                   write_slot = 0;
	logic [TOTAL_W-1:0]   limit_reg = '0;
	logic [CONF_W-1:0]    base_reg = '0;
	logic [CONF_W-1:0]    tight_reg = '0;

	reading_t             pending_readings[$];
	stim_row_t            directed_rows[$];
	int                   mismatches = 0;
	int unsigned          cycle_count = 0;
	int                   hold_requests = 0;
	int                   hold_served = 0;

	window_variation_threshold_select_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_window_variation_threshold_select_core failed");
		$finish;
	end

	function automatic longint unsigned window_variation(window_t w);
		longint unsigned acc;
		longint          d;
		int              p;
		acc = 0;
		for (int i = 0; i < WINDOW_DEPTH; i++) begin
			p = (i == 0) ? WINDOW_DEPTH - 1 : i - 1;
			d = longint'(w[i]) - longint'(w[p]);
			acc += 64'((d < 0) ? -d : d);
		end
		return acc;
	endfunction

	function automatic reading_t predict_reading(logic [31:0] s, logic [31:0] m, logic [31:0] v);
		window_t         a;
		window_t         b;
		window_t         c;
		longint unsigned sum;
		reading_t        r;
		a = spread_win;
		b = mid_win;
		c = vol_win;
		a[write_slot] = s;
		b[write_slot] = m;
		c[write_slot] = v;
		sum = window_variation(a) + window_variation(b) + window_variation(c);
		if (sum > TOTAL_MAX) begin
			sum = TOTAL_MAX;
		end
		r.total    = sum[TOTAL_W-1:0];
		r.unstable = r.total > limit_reg;
		r.conf     = r.unstable ? tight_reg : base_reg;
		return r;
	endfunction

	function automatic void absorb_sample(logic [31:0] s, logic [31:0] m, logic [31:0] v,
			bit typed, reading_t want);
		reading_t r;
		r = predict_reading(s, m, v);
		spread_win[write_slot] = s;
		mid_win[write_slot]    = m;
		vol_win[write_slot]    = v;
		write_slot = (write_slot + 1) % WINDOW_DEPTH;
		pending_readings.push_back(typed ? want : r);
	endfunction

	task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
		$display("%0t mismatch on %s: got %0h, want %0h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_results
		reading_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_readings.size() == 0) begin
				report_mismatch("item with nothing pending", 64'(m_axis_tdata), 64'd0);
			end else begin
				want = pending_readings.pop_front();
				if (m_axis_tdata[37:0] !== want.total)
					report_mismatch("instability_total", 64'(m_axis_tdata[37:0]),
						64'(want.total));
				if (m_axis_tuser[0] !== want.unstable)
					report_mismatch("is_unstable", 64'(m_axis_tuser[0]), 64'(want.unstable));
				if (m_axis_tdata[53:38] !== want.conf)
					report_mismatch("confidence_out", 64'(m_axis_tdata[53:38]),
						64'(want.conf));
				if (m_axis_tdata[55:54] !== 2'b00)
					report_mismatch("tdata padding", 64'(m_axis_tdata[55:54]), 64'd0);
			end
		end
	end

	// receiver: changing stall patterns, plus long hold-offs on request
	initial begin : receiver
		int mode;
		int stretch;
		int tick;
		mode = 0;
		stretch = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			tick++;
			if (hold_served != hold_requests) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_served++;
			end else begin
				if (stretch == 0) begin
					mode = $urandom_range(0, 3);
					stretch = $urandom_range(20, 200);
				end
				stretch--;
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 4) == 0);
					default: m_axis_tready <= (tick % 3 == 0);
				endcase
			end
		end
	end

	task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LIMIT: limit_reg = val[TOTAL_W-1:0];
			REG_BASE:  base_reg  = val[CONF_W-1:0];
			REG_TIGHT: tight_reg = val[CONF_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_sample(logic [31:0] s, logic [31:0] m, logic [31:0] v,
			bit typed = 0, reading_t want = '0);
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {v, m, s};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		absorb_sample(s, m, v, typed, want);
	endtask

	task automatic idle_cycles(int n);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] draw_sample(bit small_range);
		int r;
		r = $urandom_range(0, 15);
		if (small_range) begin
			return (r < 14) ? 32'($urandom_range(0, 8192)) - 32'd4096 : 32'h0001_0000;
		end
		case (r)
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return 32'($urandom_range(0, 8192)) - 32'd4096;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_phase(bit small_range);
		int burst_left;
		burst_left = 0;
		for (int n = 0; n < PHASE_ITEMS; n++) begin
			if (n == 40) begin
				hold_requests++;
				burst_left = 30;
			end
			if (n == 120) begin
				drain_results();
			end
			if (burst_left == 0) begin
				if ($urandom_range(0, 3) != 0) begin
					idle_cycles($urandom_range(1, 8));
				end
				burst_left = $urandom_range(1, 24);
			end
			send_sample(draw_sample(small_range), draw_sample(small_range),
				draw_sample(small_range));
			burst_left--;
		end
	endtask

	function automatic void add_row(logic [31:0] s, logic [31:0] m, logic [31:0] v,
			bit typed = 0, reading_t want = '0);
		stim_row_t row;
		row.spread = s;
		row.mid    = m;
		row.vol    = v;
		row.typed  = typed;
		row.want   = want;
		directed_rows.push_back(row);
	endfunction

	initial begin : stimulus
		logic [31:0]        s;
		logic [31:0]        m;
		logic [31:0]        v;
		logic [31:0]        alt;
		reading_t           probe;
		logic [TOTAL_W-1:0] lim;
		logic [CONF_W-1:0]  base;
		logic [CONF_W-1:0]  tight;
		bit                 small_range;

		// registers still at reset: limit 0, both confidences 0
		add_row(32'h0, 32'h0, 32'h0, 1, '{38'h0, 1'b0, 16'h0});
		add_row(32'h8000_0000, 32'h0, 32'h0, 1, '{38'h1_0000_0000, 1'b1, 16'h0});
		add_row(32'h7FFF_FFFF, 32'h0, 32'h0, 1, '{38'h1_FFFF_FFFE, 1'b1, 16'h0});
		// alternating extremes over a whole window: every neighbour pair maximal
		for (int k = 0; k < WINDOW_DEPTH; k++) begin
			alt = k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			if (k == WINDOW_DEPTH - 1)
				add_row(alt, alt, alt, 1, '{38'h2F_FFFF_FFD0, 1'b0, 16'hFFFF});
			else
				add_row(alt, alt, alt);
		end
		add_row(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
		add_row(32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000);
		add_row(32'h0001_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i]) begin
			if (i == CFG_ROW) begin
				drain_results();
				write_register(REG_LIMIT, CFG_W'(TOTAL_MAX));
				write_register(REG_BASE, CFG_W'(16'hFFFF));
				write_register(REG_TIGHT, CFG_W'(16'h0000));
				write_register(REG_UNUSED, '1);
			end
			send_sample(directed_rows[i].spread, directed_rows[i].mid, directed_rows[i].vol,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// total equal to the limit stays stable; one above goes unstable
		drain_results();
		write_register(REG_BASE, CFG_W'(16'h1234));
		write_register(REG_TIGHT, CFG_W'(16'hABCD));
		for (int k = 0; k < 2; k++) begin
			s = $urandom;
			m = $urandom;
			v = $urandom;
			probe = predict_reading(s, m, v);
			drain_results();
			write_register(REG_LIMIT, CFG_W'(probe.total - TOTAL_W'(k)));
			send_sample(s, m, v);
		end

		for (int ph = 0; ph < 6; ph++) begin
			drain_results();
			base = CONF_W'($urandom);
			tight = CONF_W'($urandom);
			small_range = 0;
			case (ph)
				0: lim = '0;
				1: begin
					lim = TOTAL_W'(TOTAL_MAX);
					base = '0;
					tight = '1;
				end
				2: lim = TOTAL_W'({32'($urandom_range(8, 24)), 32'($urandom)});
				3: begin
					lim = TOTAL_W'($urandom_range(0, 300000));
					small_range = 1;
				end
				4: lim = TOTAL_W'({32'($urandom), 32'($urandom)});
				default: begin
					lim = TOTAL_W'($urandom_range(50000, 200000));
					base = '1;
					tight = '0;
					small_range = 1;
				end
			endcase
			write_register(REG_LIMIT, CFG_W'(lim));
			write_register(REG_BASE, CFG_W'(base));
			write_register(REG_TIGHT, CFG_W'(tight));
			if (ph[0]) begin
				write_register(REG_UNUSED, CFG_W'({32'($urandom), 32'($urandom)}));
			end
			run_phase(small_range);
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_window_variation_threshold_select_core passed");
		end else begin
			$display("tb_window_variation_threshold_select_core failed");
		end
		$finish;
	end

endmodule
